FILE: src/circle_contact_impulse_resolve_assert.svh
// ----------------------------------------------------------------------------
// Contact resolver assertion macros
// Concurrent assertion helpers shared by the contact resolver RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_CONTACT_IMPULSE_RESOLVE_ASSERT_SVH
`define CIRCLE_CONTACT_IMPULSE_RESOLVE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CCIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CCIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ccir_pkg.sv
// ----------------------------------------------------------------------------
// Contact resolver package
// Shared widths, constants and pipeline payload types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccir_pkg;

  localparam int CCIR_FRAC_BITS = 16;

  localparam int SQRT_RAD_W  = 66;
  localparam int SQRT_ROOT_W = 33;
  localparam int SQRT_REM_W  = 37;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_QUO_W = 33;

  localparam int RATIO_BITS = 28;
  localparam int REST_W     = 17;
  localparam int REST_ONE   = 65536;
  localparam int REST_RESET = 32768;

  typedef struct packed {
    logic signed [31:0] apx;
    logic signed [31:0] apy;
    logic signed [31:0] bpx;
    logic signed [31:0] bpy;
    logic signed [31:0] avx;
    logic signed [31:0] avy;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic [30:0]        ra;
    logic [30:0]        rb;
  } ccir_item_t;

  typedef struct packed {
    ccir_item_t         it;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } ccir_side_a_t;

  typedef struct packed {
    ccir_item_t  it;
    logic        sx;
    logic        sy;
    logic        near;
    logic        contact;
    logic        tz;
    logic [31:0] pen;
  } ccir_side_b_t;

endpackage

FILE: src/circle_contact_impulse_resolve.sv
// ----------------------------------------------------------------------------
// Circle contact impulse resolver
// Resolves one contact between two circular bodies per transaction.
// ----------------------------------------------------------------------------
// Usage: drive the twelve body fields and raise start; the transaction is
// taken at a rising edge where start is high and busy is low. busy is high
// only in the cycle after a reset cycle, so a new transaction can be taken
// in every cycle and the sustained rate is one item per clock.
// The result of a transaction leaves the output register together with done.
// The pipeline is the 33-stage square root pipeline, the 33-stage divider
// pipelines for the normal, pushes and mass ratios, and twelve arithmetic
// stages around them.
// done marks each result for exactly one cycle; the receiver cannot stall,
// so nothing is held back. restitution is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while no transaction is in
// flight, as the block itself does not enforce this.
// Reset is synchronous: it empties the pipeline, drops done and sets
// restitution to one half.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "circle_contact_impulse_resolve_assert.svh"

module circle_contact_impulse_resolve import ccir_pkg::*; #(
  parameter int FRAC_BITS = CCIR_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_wr_en,
  input  logic [REST_W-1:0]  cfg_wr_data,
  input  logic signed [31:0] a_pos_x,
  input  logic signed [31:0] a_pos_y,
  input  logic signed [31:0] b_pos_x,
  input  logic signed [31:0] b_pos_y,
  input  logic signed [31:0] a_vel_x,
  input  logic signed [31:0] a_vel_y,
  input  logic signed [31:0] b_vel_x,
  input  logic signed [31:0] b_vel_y,
  input  logic [31:0]        a_mass,
  input  logic [31:0]        b_mass,
  input  logic [30:0]        a_radius,
  input  logic [30:0]        b_radius,
  output logic               done,
  output logic signed [31:0] a_pos_x_out,
  output logic signed [31:0] a_pos_y_out,
  output logic signed [31:0] b_pos_x_out,
  output logic signed [31:0] b_pos_y_out,
  output logic signed [31:0] a_vel_x_out,
  output logic signed [31:0] a_vel_y_out,
  output logic signed [31:0] b_vel_x_out,
  output logic signed [31:0] b_vel_y_out,
  output logic               in_contact,
  output logic               impulse_applied
);

  localparam int N_W    = FRAC_BITS + 2;
  localparam int PROD_W = FRAC_BITS + 40;
  localparam int LAT    = 3 + SQRT_ROOT_W + 2 + DIV_QUO_W + 7;
  localparam logic [32:0] DIST_ONE = 33'(1) << FRAC_BITS;
  localparam logic [32:0] DIST_EPS = 33'(((2 ** FRAC_BITS) + 5000) / 10000);
  localparam logic signed [N_W-1:0] N_ONE = N_W'(1) << FRAC_BITS;
  localparam logic [31:0] RATIO_HALF = 32'(1) << (RATIO_BITS - 1);

  function automatic logic signed [PROD_W-1:0] trunc_q(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    r = v >>> FRAC_BITS;
    if (v[PROD_W-1] && (v[FRAC_BITS-1:0] != '0)) begin
      r = r + PROD_W'(1);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = $signed({{(PROD_W-32){1'b0}}, 32'h7fff_ffff});
    lo = $signed({{(PROD_W-32){1'b1}}, 32'h8000_0000});
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [PROD_W-1:0] sx32(input logic signed [31:0] v);
    return $signed({{(PROD_W-32){v[31]}}, v});
  endfunction

  logic [REST_W-1:0] restitution;
  logic              in_fire;
  ccir_item_t        item_in;

  assign in_fire = start && !busy;
  assign item_in = '{apx: a_pos_x, apy: a_pos_y, bpx: b_pos_x, bpy: b_pos_y,
                     avx: a_vel_x, avy: a_vel_y, bvx: b_vel_x, bvy: b_vel_y,
                     ma: a_mass, mb: b_mass, ra: a_radius, rb: b_radius};

  always_ff @(posedge clk) begin
    busy <= rst;
    if (rst) begin
      restitution <= REST_W'(REST_RESET);
    end else if (cfg_wr_en) begin
      restitution <= cfg_wr_data;
    end
  end

  // Stages 1 to 3: offset, magnitudes, squares and the radicand.
  logic               v1, v2, v3;
  ccir_item_t         it1, it2, it3;
  logic signed [32:0] dx1, dy1, dx2, dy2, dx3, dy3;
  logic [31:0]        ux1, uy1;
  logic [63:0]        sqx2, sqy2;
  logic [SQRT_RAD_W-1:0] rad3;
  logic signed [32:0] dxc, dyc, axc, ayc;

  always_comb begin
    dxc = {b_pos_x[31], b_pos_x} - {a_pos_x[31], a_pos_x};
    dyc = {b_pos_y[31], b_pos_y} - {a_pos_y[31], a_pos_y};
    axc = dxc[32] ? -dxc : dxc;
    ayc = dyc[32] ? -dyc : dyc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_fire;
      v2 <= v1;
      v3 <= v2;
    end
    it1  <= item_in;
    dx1  <= dxc;
    dy1  <= dyc;
    ux1  <= axc[31:0];
    uy1  <= ayc[31:0];
    it2  <= it1;
    dx2  <= dx1;
    dy2  <= dy1;
    sqx2 <= 64'(ux1) * 64'(ux1);
    sqy2 <= 64'(uy1) * 64'(uy1);
    it3  <= it2;
    dx3  <= dx2;
    dy3  <= dy2;
    rad3 <= SQRT_RAD_W'(65'(sqx2) + 65'(sqy2));
  end

  // Distance.
  logic [SQRT_ROOT_W-1:0] root;
  logic                   vsq;
  ccir_side_a_t           sa_in, sa;

  assign sa_in = '{it: it3, dx: dx3, dy: dy3};

  ccir_sqrt u_sqrt (
    .clk      (clk),
    .radicand (rad3),
    .root     (root)
  );

  ccir_delay #(.WIDTH(1), .DEPTH(SQRT_ROOT_W)) u_sqrt_vld (
    .clk (clk),
    .rst (rst),
    .d   (v3),
    .q   (vsq)
  );

  ccir_delay #(.WIDTH($bits(ccir_side_a_t)), .DEPTH(SQRT_ROOT_W)) u_sqrt_side (
    .clk (clk),
    .rst (rst),
    .d   (sa_in),
    .q   (sa)
  );

  // Stage 4: near-coincidence, contact test, penetration and divisors.
  logic        near_c, contact_c, tz_c;
  logic [32:0] dist_c, total_c, adx_c, ady_c;
  logic [31:0] rsum_c;

  always_comb begin
    near_c    = root <= DIST_EPS;
    dist_c    = near_c ? DIST_ONE : root;
    rsum_c    = {1'b0, sa.it.ra} + {1'b0, sa.it.rb};
    contact_c = dist_c <= {1'b0, rsum_c};
    total_c   = {1'b0, sa.it.ma} + {1'b0, sa.it.mb};
    tz_c      = total_c == '0;
    adx_c     = sa.dx[32] ? 33'(-sa.dx) : 33'(sa.dx);
    ady_c     = sa.dy[32] ? 33'(-sa.dy) : 33'(sa.dy);
  end

  logic        v4, v5;
  ccir_item_t  it4, it5;
  logic        near4, contact4, tz4, sx4, sy4, near5, contact5, tz5, sx5, sy5;
  logic [32:0] dist4, den4, dist5, den5;
  logic [31:0] pen4, pen5;
  logic [63:0] nxn4, nyn4, nxn5, nyn5, pmb5, pma5, rnb5, rna5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v4 <= vsq;
      v5 <= v4;
    end
    it4      <= sa.it;
    near4    <= near_c;
    contact4 <= contact_c;
    tz4      <= tz_c;
    sx4      <= sa.dx[32];
    sy4      <= sa.dy[32];
    dist4    <= dist_c;
    den4     <= tz_c ? 33'(1) : total_c;
    pen4     <= rsum_c - dist_c[31:0];
    nxn4     <= 64'(adx_c[31:0]) << FRAC_BITS;
    nyn4     <= 64'(ady_c[31:0]) << FRAC_BITS;
    it5      <= it4;
    near5    <= near4;
    contact5 <= contact4;
    tz5      <= tz4;
    sx5      <= sx4;
    sy5      <= sy4;
    dist5    <= dist4;
    den5     <= den4;
    pen5     <= pen4;
    nxn5     <= nxn4;
    nyn5     <= nyn4;
    pmb5     <= 64'(pen4) * 64'(it4.mb);
    pma5     <= 64'(pen4) * 64'(it4.ma);
    rnb5     <= 64'(it4.mb) << RATIO_BITS;
    rna5     <= 64'(it4.ma) << RATIO_BITS;
  end

  // Normal, pushes and mass ratios.
  logic [DIV_QUO_W-1:0] qnx, qny, qma, qmb, qra, qrb;
  logic                 vdv;
  ccir_side_b_t         sb_in, sb;

  assign sb_in = '{it: it5, sx: sx5, sy: sy5, near: near5, contact: contact5,
                   tz: tz5, pen: pen5};

  ccir_div u_div_nx (.clk(clk), .num(nxn5), .den(dist5), .quo(qnx));
  ccir_div u_div_ny (.clk(clk), .num(nyn5), .den(dist5), .quo(qny));
  ccir_div u_div_ma (.clk(clk), .num(pmb5), .den(den5),  .quo(qma));
  ccir_div u_div_mb (.clk(clk), .num(pma5), .den(den5),  .quo(qmb));
  ccir_div u_div_ra (.clk(clk), .num(rnb5), .den(den5),  .quo(qra));
  ccir_div u_div_rb (.clk(clk), .num(rna5), .den(den5),  .quo(qrb));

  ccir_delay #(.WIDTH(1), .DEPTH(DIV_QUO_W)) u_div_vld (
    .clk (clk),
    .rst (rst),
    .d   (v5),
    .q   (vdv)
  );

  ccir_delay #(.WIDTH($bits(ccir_side_b_t)), .DEPTH(DIV_QUO_W)) u_div_side (
    .clk (clk),
    .rst (rst),
    .d   (sb_in),
    .q   (sb)
  );

  // Stage 6: signed normal, push amounts, ratios, relative velocity.
  logic signed [N_W-1:0] nxm_c, nym_c;

  always_comb begin
    nxm_c = $signed({1'b0, qnx[FRAC_BITS:0]});
    nym_c = $signed({1'b0, qny[FRAC_BITS:0]});
  end

  logic                  v6, contact6;
  ccir_item_t            it6;
  logic signed [N_W-1:0] nx6, ny6;
  logic [31:0]           mva6, mvb6, rta6, rtb6;
  logic signed [32:0]    dvx6, dvy6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= vdv;
    end
    it6      <= sb.it;
    contact6 <= sb.contact;
    nx6      <= sb.near ? N_ONE : (sb.sx ? -nxm_c : nxm_c);
    ny6      <= sb.near ? '0 : (sb.sy ? -nym_c : nym_c);
    mva6     <= sb.tz ? (sb.pen >> 1) : qma[31:0];
    mvb6     <= sb.tz ? (sb.pen >> 1) : qmb[31:0];
    rta6     <= sb.tz ? RATIO_HALF : qra[31:0];
    rtb6     <= sb.tz ? RATIO_HALF : qrb[31:0];
    dvx6     <= {sb.it.bvx[31], sb.it.bvx} - {sb.it.avx[31], sb.it.avx};
    dvy6     <= {sb.it.bvy[31], sb.it.bvy} - {sb.it.avy[31], sb.it.avy};
  end

  // Stage 7: products along the normal.
  logic                     v7, contact7;
  ccir_item_t               it7;
  logic signed [N_W-1:0]    nx7, ny7;
  logic [31:0]              rta7, rtb7;
  logic signed [PROD_W-1:0] pax7, pay7, pbx7, pby7, vnx7, vny7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    it7      <= it6;
    contact7 <= contact6;
    nx7      <= nx6;
    ny7      <= ny6;
    rta7     <= rta6;
    rtb7     <= rtb6;
    pax7     <= nx6 * $signed({1'b0, mva6});
    pay7     <= ny6 * $signed({1'b0, mva6});
    pbx7     <= nx6 * $signed({1'b0, mvb6});
    pby7     <= ny6 * $signed({1'b0, mvb6});
    vnx7     <= dvx6 * nx6;
    vny7     <= dvy6 * ny6;
  end

  // Stage 8: corrected positions and normal relative velocity.
  logic                     v8, contact8;
  ccir_item_t               it8;
  logic signed [N_W-1:0]    nx8, ny8;
  logic [31:0]              rta8, rtb8;
  logic signed [31:0]       pos8 [4];
  logic signed [PROD_W-1:0] van8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    it8      <= it7;
    contact8 <= contact7;
    nx8      <= nx7;
    ny8      <= ny7;
    rta8     <= rta7;
    rtb8     <= rtb7;
    pos8[0]  <= contact7 ? sat32(sx32(it7.apx) - trunc_q(pax7)) : it7.apx;
    pos8[1]  <= contact7 ? sat32(sx32(it7.apy) - trunc_q(pay7)) : it7.apy;
    pos8[2]  <= contact7 ? sat32(sx32(it7.bpx) + trunc_q(pbx7)) : it7.bpx;
    pos8[3]  <= contact7 ? sat32(sx32(it7.bpy) + trunc_q(pby7)) : it7.bpy;
    van8     <= trunc_q(vnx7) + trunc_q(vny7);
  end

  // Stage 9: impulse magnitude scaled by one plus restitution.
  logic [REST_W-1:0]        e_c;
  logic signed [PROD_W-1:0] nvan_c;
  logic [52:0]              kprod_c;

  always_comb begin
    e_c     = (restitution > REST_W'(REST_ONE)) ? REST_W'(REST_ONE) : restitution;
    nvan_c  = -van8;
    kprod_c = 53'(nvan_c[34:0]) * 53'(18'(REST_ONE) + 18'(e_c));
  end

  logic                  v9, contact9, appr9;
  ccir_item_t            it9;
  logic signed [N_W-1:0] nx9, ny9;
  logic [31:0]           rta9, rtb9;
  logic signed [31:0]    pos9 [4];
  logic [36:0]           kk9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    it9      <= it8;
    contact9 <= contact8;
    appr9    <= contact8 && (van8[PROD_W-1] || (van8 == '0));
    nx9      <= nx8;
    ny9      <= ny8;
    rta9     <= rta8;
    rtb9     <= rtb8;
    pos9     <= pos8;
    kk9      <= kprod_c[52:16];
  end

  // Stage 10: per-body share of the impulse.
  logic [65:0] kpa_c, kpb_c;

  always_comb begin
    kpa_c = 66'(kk9) * 66'(rta9);
    kpb_c = 66'(kk9) * 66'(rtb9);
  end

  logic                  v10, contact10, appr10;
  ccir_item_t            it10;
  logic signed [N_W-1:0] nx10, ny10;
  logic signed [31:0]    pos10 [4];
  logic [37:0]           ka10, kb10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    it10      <= it9;
    contact10 <= contact9;
    appr10    <= appr9;
    nx10      <= nx9;
    ny10      <= ny9;
    pos10     <= pos9;
    ka10      <= kpa_c[65:28];
    kb10      <= kpb_c[65:28];
  end

  // Stage 11: velocity change products.
  logic                     v11, contact11, appr11;
  ccir_item_t               it11;
  logic signed [31:0]       pos11 [4];
  logic signed [PROD_W-1:0] dax11, day11, dbx11, dby11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= v10;
    end
    it11      <= it10;
    contact11 <= contact10;
    appr11    <= appr10;
    pos11     <= pos10;
    dax11     <= nx10 * $signed({1'b0, ka10});
    day11     <= ny10 * $signed({1'b0, ka10});
    dbx11     <= nx10 * $signed({1'b0, kb10});
    dby11     <= ny10 * $signed({1'b0, kb10});
  end

  // Stage 12: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v11;
    end
    a_pos_x_out     <= pos11[0];
    a_pos_y_out     <= pos11[1];
    b_pos_x_out     <= pos11[2];
    b_pos_y_out     <= pos11[3];
    a_vel_x_out     <= appr11 ? sat32(sx32(it11.avx) - trunc_q(dax11)) : it11.avx;
    a_vel_y_out     <= appr11 ? sat32(sx32(it11.avy) - trunc_q(day11)) : it11.avy;
    b_vel_x_out     <= appr11 ? sat32(sx32(it11.bvx) + trunc_q(dbx11)) : it11.bvx;
    b_vel_y_out     <= appr11 ? sat32(sx32(it11.bvy) + trunc_q(dby11)) : it11.bvy;
    in_contact      <= contact11;
    impulse_applied <= appr11;
  end

  `CCIR_ASSERT_NOW(a_impulse_needs_contact, clk, rst, done && impulse_applied, in_contact, "impulse without contact")
  `CCIR_ASSERT_NOW(a_done_has_source, clk, rst, done, $past(in_fire, LAT), "result without a matching transaction")
  `CCIR_ASSERT_NOW(a_free_keeps_velocity, clk, rst, done && !in_contact, a_vel_x_out == $past(a_vel_x, LAT), "velocity changed without contact")

endmodule

FILE: src/ccir_delay.sv
// ----------------------------------------------------------------------------
// Contact resolver delay line
// Fixed-depth register chain that keeps side data aligned with long units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccir_delay import ccir_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = SQRT_ROOT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] pipe [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        pipe[k] <= '0;
      end
    end else begin
      pipe[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  assign q = pipe[DEPTH-1];

endmodule

FILE: src/ccir_sqrt.sv
// ----------------------------------------------------------------------------
// Contact resolver square root
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccir_sqrt import ccir_pkg::*; (
  input  logic                   clk,
  input  logic [SQRT_RAD_W-1:0]  radicand,
  output logic [SQRT_ROOT_W-1:0] root
);

  localparam int N = SQRT_ROOT_W;

  logic [SQRT_RAD_W-1:0]  rad_c [N];
  logic [SQRT_REM_W-1:0]  rem_c [N];
  logic [N-1:0]           rt_c  [N];
  logic [SQRT_RAD_W-1:0]  rad_q [N];
  logic [SQRT_REM_W-1:0]  rem_q [N];
  logic [N-1:0]           rt_q  [N];
  logic [SQRT_REM_W-1:0]  cur   [N];
  logic [SQRT_REM_W-1:0]  trial [N];
  logic                   ge    [N];

  always_comb begin
    rad_c[0] = radicand;
    rem_c[0] = '0;
    rt_c[0]  = '0;
    for (int k = 1; k < N; k++) begin
      rad_c[k] = rad_q[k-1];
      rem_c[k] = rem_q[k-1];
      rt_c[k]  = rt_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      cur[k]   = {rem_c[k][SQRT_REM_W-3:0], rad_c[k][SQRT_RAD_W-1 -: 2]};
      trial[k] = SQRT_REM_W'({rt_c[k], 2'b01});
      ge[k]    = cur[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      rad_q[k] <= rad_c[k] << 2;
      rem_q[k] <= ge[k] ? cur[k] - trial[k] : cur[k];
      rt_q[k]  <= {rt_c[k][N-2:0], ge[k]};
    end
  end

  assign root = rt_q[N-1];

endmodule

FILE: src/ccir_div.sv
// ----------------------------------------------------------------------------
// Contact resolver divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccir_div import ccir_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W,
  parameter int QUO_W = DIV_QUO_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_c [QUO_W];
  logic [DEN_W-1:0] den_c [QUO_W];
  logic [QUO_W-1:0] low_c [QUO_W];
  logic [QUO_W-1:0] quo_c [QUO_W];
  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W:0]   cur   [QUO_W];
  logic [DEN_W:0]   diff  [QUO_W];
  logic             ge    [QUO_W];

  always_comb begin
    rem_c[0] = DEN_W'(num[NUM_W-1:QUO_W]);
    den_c[0] = den;
    low_c[0] = num[QUO_W-1:0];
    quo_c[0] = '0;
    for (int k = 1; k < QUO_W; k++) begin
      rem_c[k] = rem_q[k-1];
      den_c[k] = den_q[k-1];
      low_c[k] = low_q[k-1];
      quo_c[k] = quo_q[k-1];
    end
    for (int k = 0; k < QUO_W; k++) begin
      cur[k]  = {rem_c[k], low_c[k][QUO_W-1]};
      diff[k] = cur[k] - {1'b0, den_c[k]};
      ge[k]   = cur[k] >= {1'b0, den_c[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      rem_q[k] <= ge[k] ? diff[k][DEN_W-1:0] : cur[k][DEN_W-1:0];
      den_q[k] <= den_c[k];
      low_q[k] <= low_c[k] << 1;
      quo_q[k] <= {quo_c[k][QUO_W-2:0], ge[k]};
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule
